// ===== rtl/cpuw_pkg.sv =====
// Shared types, constants and helper functions for the unit-window point clipper.
package cpuw_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 16;
    localparam int MAX_PASSES  = 4;

    // Magnitudes of deltas, negated coordinates and (1.0 - coordinate) all fit in MAG_W bits.
    localparam int MAG_W      = (COORD_WIDTH + 1 > FRAC_BITS + 2) ? COORD_WIDTH + 1
                                                                  : FRAC_BITS + 2;
    localparam int OP_W       = MAG_W + 1;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int QUO_W      = COORD_WIDTH;
    localparam int HI_W       = PROD_W - QUO_W;
    localparam int REM_W      = COORD_WIDTH + 2;
    localparam int SUM_W      = COORD_WIDTH + 2;
    localparam int CNT_W      = $clog2(MAG_W + 1);
    localparam int PASS_W     = $clog2(MAX_PASSES + 1);
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * COORD_WIDTH + STATUS_W + 7) / 8) * 8;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [OP_W-1:0]        t_op;
    typedef logic        [MAG_W-1:0]       t_mag;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic        [STATUS_W-1:0]    t_status;
    typedef logic        [3:0]             t_outcode;

    localparam t_status ST_INSIDE     = 2'd0;
    localparam t_status ST_CLIPPED    = 2'd1;
    localparam t_status ST_ZERO_DELTA = 2'd2;
    localparam t_status ST_GAVE_UP    = 2'd3;

    localparam t_outcode OC_LEFT  = 4'h1;
    localparam t_outcode OC_RIGHT = 4'h2;
    localparam t_outcode OC_BELOW = 4'h4;
    localparam t_outcode OC_ABOVE = 4'h8;

    localparam t_coord CW_MAX     = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord CW_MIN     = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam t_op    FX_ONE     = t_op'(longint'(1) << FRAC_BITS);
    localparam t_coord FX_ONE_SAT = (FRAC_BITS <= COORD_WIDTH - 2)
                                    ? t_coord'(longint'(1) << FRAC_BITS) : CW_MAX;

    // Request to the shared multiply-divide unit: |a| * |b| / |d| with a result sign.
    typedef struct packed {
        logic start;
        logic neg;
        t_mag a;
        t_mag b;
        t_mag d;
    } t_md_req;

    typedef struct packed {
        logic done;
        t_sum q;
    } t_md_rsp;

    function automatic t_coord sat_sum(input t_sum v);
        t_coord r;
        if (v > t_sum'(CW_MAX)) begin
            r = CW_MAX;
        end else if (v < t_sum'(CW_MIN)) begin
            r = CW_MIN;
        end else begin
            r = v[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic t_outcode outcode(input t_coord x, input t_coord y);
        t_op      xe;
        t_op      ye;
        t_outcode c;
        xe = t_op'(x);
        ye = t_op'(y);
        c  = '0;
        if (xe < 0)      c = c | OC_LEFT;
        if (xe > FX_ONE) c = c | OC_RIGHT;
        if (ye < 0)      c = c | OC_BELOW;
        if (ye > FX_ONE) c = c | OC_ABOVE;
        return c;
    endfunction

    function automatic t_mag mag_of(input t_op v);
        t_op n;
        n = v[OP_W-1] ? -v : v;
        return n[MAG_W-1:0];
    endfunction

endpackage

// ===== rtl/cpuw_muldiv.sv =====
// Shared iterative unit: shift-add multiply followed by restoring divide, signed result.
module cpuw_muldiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpuw_pkg::t_md_req i_req,
    output cpuw_pkg::t_md_rsp o_rsp
);
    import cpuw_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_CHK, S_DIV} t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   r_mc;
    t_mag                r_mp;
    t_mag                r_d;
    logic                r_neg;
    logic [REM_W-1:0]    r_rem;
    logic [QUO_W-1:0]    r_quo;
    logic                r_done;
    t_sum                r_q;

    logic [PROD_W-1:0]   n_prod;
    logic [HI_W-1:0]     n_hi;
    logic                n_ovf;
    logic [REM_W-1:0]    n_trial;
    logic                n_ge;
    logic [REM_W-1:0]    n_diff;
    logic [QUO_W-1:0]    n_quo;
    t_sum                n_qmag;
    t_sum                n_clamp;

    always_comb begin
        n_prod  = r_prod + r_mc;
        n_hi    = r_prod[PROD_W-1:QUO_W];
        n_ovf   = n_hi >= HI_W'(r_d);
        n_trial = {r_rem[REM_W-2:0], r_prod[QUO_W-1]};
        n_ge    = n_trial >= REM_W'(r_d);
        n_diff  = n_trial - REM_W'(r_d);
        n_quo   = {r_quo[QUO_W-2:0], n_ge};
        n_qmag  = t_sum'({1'b0, n_quo});
        n_clamp = t_sum'(1) <<< QUO_W;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (i_req.start) begin
                        r_prod  <= '0;
                        r_mc    <= PROD_W'(i_req.a);
                        r_mp    <= i_req.b;
                        r_d     <= i_req.d;
                        r_neg   <= i_req.neg;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_done <= 1'b0;
                    // Stops as soon as no multiplier bits remain.
                    if (r_mp == '0) begin
                        r_state <= S_CHK;
                    end else begin
                        if (r_mp[0]) r_prod <= n_prod;
                        r_mc <= r_mc << 1;
                        r_mp <= r_mp >> 1;
                    end
                end
                S_CHK: begin
                    // A quotient this large saturates the coordinate anyway.
                    if (n_ovf) begin
                        r_q     <= r_neg ? -n_clamp : n_clamp;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_done  <= 1'b0;
                        r_rem   <= REM_W'(n_hi);
                        r_cnt   <= CNT_W'(QUO_W);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= n_ge ? n_diff : n_trial;
                    r_quo  <= n_quo;
                    r_prod <= r_prod << 1;
                    r_cnt  <= r_cnt - CNT_W'(1);
                    r_done <= (r_cnt == CNT_W'(1));
                    if (r_cnt == CNT_W'(1)) begin
                        r_q     <= r_neg ? -n_qmag : n_qmag;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        o_rsp.q    = r_q;
    end

endmodule

// ===== rtl/clip_point_to_unit_window.sv =====
// Top level: clips a cursor point into the unit window with a pass sequencer.
//
// Usage: each beat on the slave stream carries a new point (new_x, new_y) in
// signed fixed point with 16 fraction bits. The block remembers that point,
// unclipped, as the anchor for the next beat, and pulls the new point toward
// the previous one along the segment, one window edge per pass, until it lies
// in [0, 1] x [0, 1]. Each beat yields exactly one master beat with the placed
// point and a status: inside, clipped, zero delta (left outside) or gave up
// (placed at the origin after four passes).
// A point that needs no clipping is written to the output register from the
// evaluate state once that register is free, and the slave side is ready again
// then. Each pass runs one product and one quotient through the shared
// multiply-divide unit: the issue, the multiply steps (one per multiplier bit up
// to the highest set one), a step to see the multiplier empty, a range check,
// the divide steps unless that check saturates, and taking the quotient.
// The slave side is ready only while no point is in work; one point is in
// flight at a time. A finished result sits in the output register, and the
// next beat is taken even while that result waits; if the receiver stalls,
// the following result waits in the sequencer until the register frees up.
// Reset clears the remembered point to the origin and drops any pending beat.
module clip_point_to_unit_window (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // new_x, new_y
    input  logic [cpuw_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // clip_x, clip_y, clip_status, zero padding
    output logic [cpuw_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);
    import cpuw_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_WAIT} t_state;
    typedef enum logic [1:0] {E_LEFT, E_RIGHT, E_BELOW, E_ABOVE} t_edge;

    t_state            r_state;
    t_edge             r_edge;
    logic [PASS_W-1:0] r_pass;
    t_coord            r_x;
    t_coord            r_y;
    t_coord            r_px;   // remembered point for the next beat
    t_coord            r_py;
    t_coord            r_ax;   // anchor of the point in work
    t_coord            r_ay;
    logic              r_out_valid;
    t_coord            r_out_x;
    t_coord            r_out_y;
    t_status           r_out_status;

    t_outcode          n_code;
    t_op               n_xd;
    t_op               n_yd;
    t_op               n_a;
    t_op               n_b;
    t_op               n_d;
    t_edge             n_edge;
    logic              n_zero;
    logic              n_fin;
    logic              n_out_free;
    logic              n_emit;
    t_coord            n_upd_x;
    t_coord            n_upd_y;
    t_md_req           md_req;
    t_md_rsp           md_rsp;

    always_comb begin
        n_code = outcode(r_x, r_y);
        n_xd   = t_op'(r_ax) - t_op'(r_x);
        n_yd   = t_op'(r_ay) - t_op'(r_y);
        n_zero = (n_xd == '0) || (n_yd == '0);

        // Edge priority: left, right, below, above.
        if ((n_code & OC_LEFT) != '0) begin
            n_edge = E_LEFT;
            n_a    = -t_op'(r_x);
            n_b    = n_yd;
            n_d    = n_xd;
        end else if ((n_code & OC_RIGHT) != '0) begin
            n_edge = E_RIGHT;
            n_a    = n_yd;
            n_b    = FX_ONE - t_op'(r_x);
            n_d    = n_xd;
        end else if ((n_code & OC_BELOW) != '0) begin
            n_edge = E_BELOW;
            n_a    = -t_op'(r_y);
            n_b    = n_xd;
            n_d    = n_yd;
        end else begin
            n_edge = E_ABOVE;
            n_a    = n_xd;
            n_b    = FX_ONE - t_op'(r_y);
            n_d    = n_yd;
        end

        n_fin      = (n_code == '0) || n_zero || (r_pass == PASS_W'(MAX_PASSES));
        n_out_free = !r_out_valid || i_m_axis_tready;
        n_emit     = (r_state == S_EVAL) && n_fin && n_out_free;

        md_req.start = (r_state == S_EVAL) && !n_fin;
        md_req.neg   = n_a[OP_W-1] ^ n_b[OP_W-1] ^ n_d[OP_W-1];
        md_req.a     = mag_of(n_a);
        md_req.b     = mag_of(n_b);
        md_req.d     = mag_of(n_d);

        n_upd_x = sat_sum(t_sum'(r_x) + md_rsp.q);
        n_upd_y = sat_sum(t_sum'(r_y) + md_rsp.q);
    end

    cpuw_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_px        <= '0;
            r_py        <= '0;
        end else begin
            // A new result may replace one that leaves in the same cycle.
            if (n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_x     <= i_s_axis_tdata[COORD_WIDTH-1:0];
                        r_y     <= i_s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
                        r_px    <= i_s_axis_tdata[COORD_WIDTH-1:0];
                        r_py    <= i_s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
                        r_ax    <= r_px;
                        r_ay    <= r_py;
                        r_pass  <= '0;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (n_fin) begin
                        // Result waits here while the output register is still full.
                        if (n_out_free) begin
                            if (n_code == '0) begin
                                r_out_x      <= r_x;
                                r_out_y      <= r_y;
                                r_out_status <= (r_pass != '0) ? ST_CLIPPED : ST_INSIDE;
                            end else if (n_zero) begin
                                r_out_x      <= r_x;
                                r_out_y      <= r_y;
                                r_out_status <= ST_ZERO_DELTA;
                            end else begin
                                r_out_x      <= '0;
                                r_out_y      <= '0;
                                r_out_status <= ST_GAVE_UP;
                            end
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_pass  <= r_pass + PASS_W'(1);
                        r_edge  <= n_edge;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (md_rsp.done) begin
                        unique case (r_edge)
                            E_LEFT: begin
                                r_y <= n_upd_y;
                                r_x <= '0;
                            end
                            E_RIGHT: begin
                                r_y <= n_upd_y;
                                r_x <= FX_ONE_SAT;
                            end
                            E_BELOW: begin
                                r_x <= n_upd_x;
                                r_y <= '0;
                            end
                            E_ABOVE: begin
                                r_x <= n_upd_x;
                                r_y <= FX_ONE_SAT;
                            end
                            default: r_x <= '0;
                        endcase
                        r_state <= S_EVAL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'({r_out_status, r_out_y, r_out_x});

endmodule

// ===== rtl/cpuw_checker.sv =====
// Port-level checks for the unit-window point clipper, bound to the top level.
module cpuw_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [cpuw_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import cpuw_pkg::*;

    t_coord  out_x;
    t_coord  out_y;
    t_status out_status;

    assign out_x      = o_m_axis_tdata[COORD_WIDTH-1:0];
    assign out_y      = o_m_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign out_status = o_m_axis_tdata[2*COORD_WIDTH+STATUS_W-1:2*COORD_WIDTH];

    // Only one point is in work at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("slave side stayed ready after taking a beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result beat changed or dropped");

    a_gave_up_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (out_status == ST_GAVE_UP) |-> (out_x == '0) && (out_y == '0))
        else $error("gave-up result not at the origin");

    a_placed_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (out_status == ST_INSIDE || out_status == ST_CLIPPED)
        |-> !out_x[COORD_WIDTH-1] && !out_y[COORD_WIDTH-1])
        else $error("placed point lies left of or below the window");

endmodule

bind clip_point_to_unit_window cpuw_checker u_cpuw_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== verif/placed_point_checker.sv =====
// Checker for the unit-window clipper: predicts each placed point and compares result beats.
`timescale 1ns / 1ps

module placed_point_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // new_x, new_y
    input  logic [cpuw_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // clip_x, clip_y, clip_status, zero padding
    input  logic [cpuw_pkg::OUT_DATA_W-1:0] i_m_tdata,
    output int                              o_mismatches,
    output int                              o_pending,
    output logic [3:0][31:0]                o_status_seen
);

    import cpuw_pkg::*;

    typedef struct packed {
        t_coord  x;
        t_coord  y;
        t_status status;
    } t_placed;

    localparam longint ONE      = longint'(1) << FRAC_BITS;
    localparam longint COORD_HI = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint COORD_LO = -(longint'(1) << (COORD_WIDTH - 1));
    localparam longint QUOT_CAP = longint'(1) << 40;

    t_placed          placed_due[$];
    t_placed          want;
    t_placed          got;
    longint           anchor_x;
    longint           anchor_y;
    int               mismatches  = 0;
    logic [3:0][31:0] status_seen = '0;

    function automatic longint clamp_coord(input longint v);
        longint r;
        r = v;
        if (v > COORD_HI) r = COORD_HI;
        if (v < COORD_LO) r = COORD_LO;
        return r;
    endfunction

    // trunc(a * b / d) with the quotient magnitude capped.
    function automatic longint scaled_step(input longint a, input longint b, input longint d);
        logic            neg;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned md;
        longint unsigned q;
        neg = ((a < 0) != (b < 0)) != (d < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        md  = (d < 0) ? -d : d;
        q   = (ma * mb) / md;
        if (q > QUOT_CAP) q = QUOT_CAP;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_outcode window_code(input longint x, input longint y);
        t_outcode c;
        c = '0;
        if (x < 0)   c = c | OC_LEFT;
        if (x > ONE) c = c | OC_RIGHT;
        if (y < 0)   c = c | OC_BELOW;
        if (y > ONE) c = c | OC_ABOVE;
        return c;
    endfunction

    // Pulls (nx, ny) toward the anchor one window edge per pass.
    function automatic t_placed place_point(input longint px, input longint py,
                                            input longint nx, input longint ny);
        longint   x;
        longint   y;
        longint   xd;
        longint   yd;
        t_outcode code;
        t_status  st;
        int       passes;
        logic     settled;
        t_placed  r;
        x       = nx;
        y       = ny;
        code    = window_code(x, y);
        st      = (code != '0) ? ST_CLIPPED : ST_INSIDE;
        passes  = 0;
        settled = (code == '0);
        while (!settled) begin
            xd = px - x;
            yd = py - y;
            if (xd == 0 || yd == 0) begin
                st      = ST_ZERO_DELTA;
                settled = 1'b1;
            end else if (passes >= MAX_PASSES) begin
                x       = 0;
                y       = 0;
                st      = ST_GAVE_UP;
                settled = 1'b1;
            end else begin
                passes++;
                if ((code & OC_LEFT) != '0) begin
                    y = clamp_coord(y + scaled_step(-x, yd, xd));
                    x = 0;
                end else if ((code & OC_RIGHT) != '0) begin
                    y = clamp_coord(y + scaled_step(yd, ONE - x, xd));
                    x = clamp_coord(ONE);
                end else if ((code & OC_BELOW) != '0) begin
                    x = clamp_coord(x + scaled_step(-y, xd, yd));
                    y = 0;
                end else begin
                    x = clamp_coord(x + scaled_step(xd, ONE - y, yd));
                    y = clamp_coord(ONE);
                end
                code    = window_code(x, y);
                settled = (code == '0);
            end
        end
        r.x      = t_coord'(x);
        r.y      = t_coord'(y);
        r.status = st;
        return r;
    endfunction

    task automatic report_field(input string what, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            placed_due.delete();
            anchor_x = 0;
            anchor_y = 0;
        end else begin
            // Retire the oldest prediction first, then queue the newly accepted point.
            if (i_m_tvalid && i_m_tready) begin
                got.x      = t_coord'(i_m_tdata[COORD_WIDTH-1:0]);
                got.y      = t_coord'(i_m_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
                got.status = t_status'(i_m_tdata[2*COORD_WIDTH+STATUS_W-1:2*COORD_WIDTH]);
                status_seen[got.status] = status_seen[got.status] + 1;
                if (placed_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, actual x %0d y %0d status %0d",
                             $time, $signed(got.x), $signed(got.y), got.status);
                end else begin
                    want = placed_due.pop_front();
                    report_field("clip_x", longint'(want.x), longint'(got.x));
                    report_field("clip_y", longint'(want.y), longint'(got.y));
                    report_field("clip_status", longint'(want.status), longint'(got.status));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                placed_due.push_back(place_point(anchor_x, anchor_y,
                    longint'(t_coord'(i_s_tdata[COORD_WIDTH-1:0])),
                    longint'(t_coord'(i_s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]))));
                anchor_x = longint'(t_coord'(i_s_tdata[COORD_WIDTH-1:0]));
                anchor_y = longint'(t_coord'(i_s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]));
            end
        end
        o_mismatches  <= mismatches;
        o_pending     <= placed_due.size();
        o_status_seen <= status_seen;
    end

endmodule

// ===== verif/clip_point_to_unit_window_test.sv =====
// Testbench top for the unit-window clipper: point stimulus, stream idling and the verdict.
`timescale 1ns / 1ps

module clip_point_to_unit_window_test;

    import cpuw_pkg::*;

    localparam int  FX          = 1 << FRAC_BITS;
    localparam int  PHASE_ITEMS = 460;
    localparam int  DRAIN_WAIT  = 300;
    localparam longint CYCLE_LIMIT = 2000000;

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    // new_x, new_y
    logic [IN_DATA_W-1:0]    i_s_axis_tdata  = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    // clip_x, clip_y, clip_status, zero padding
    logic [OUT_DATA_W-1:0]   o_m_axis_tdata;

    int                      mismatches;
    int                      pending;
    logic [3:0][31:0]        status_seen;

    int                      src_idle_pct  = 16;
    int                      dst_stall_pct = 61;
    int                      points_sent   = 0;
    longint                  cycles        = 0;
    t_coord                  last_x        = '0;
    t_coord                  last_y        = '0;

    clip_point_to_unit_window u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    placed_point_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_axis_tvalid),
        .i_s_tready    (o_s_axis_tready),
        .i_s_tdata     (i_s_axis_tdata),
        .i_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .i_m_tdata     (o_m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_status_seen (status_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls at random according to the current idle profile.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the beat was accepted.
    task automatic send_point(input t_coord x, input t_coord y);
        logic [IN_DATA_W-1:0] beat;
        beat = '0;
        beat[COORD_WIDTH-1:0]             = x;
        beat[2*COORD_WIDTH-1:COORD_WIDTH] = y;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= beat;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        last_x = x;
        last_y = y;
        points_sent++;
    endtask

    // Coordinates mostly land near the window, with boundary values, repeats of the
    // previous coordinate (zero delta) and full-range noise mixed in.
    function automatic t_coord pick_coord(input t_coord prior);
        t_coord c;
        case ($urandom_range(9))
            0: begin
                c = t_coord'($urandom);
            end
            1: begin
                c = prior;
            end
            2: begin
                case ($urandom_range(6))
                    0:       c = '0;
                    1:       c = t_coord'(FX);
                    2:       c = t_coord'(FX + 1);
                    3:       c = t_coord'(-1);
                    4:       c = t_coord'(FX - 1);
                    5:       c = CW_MAX;
                    default: c = CW_MIN;
                endcase
            end
            3: begin
                c = t_coord'(int'($urandom_range(64 * FX)) - 32 * FX);
            end
            default: begin
                c = t_coord'(int'($urandom_range(6 * FX)) - 2 * FX);
            end
        endcase
        return c;
    endfunction

    // A segment on the line y = x - k (k >= 2) passes below and right of the window,
    // so clipping bounces between the left, below and right edges until it gives up.
    task automatic send_escape_pair();
        int k;
        int a;
        int b;
        k = 2 * FX + int'($urandom_range(3 * FX));
        a = 5 * FX + int'($urandom_range(15 * FX));
        b = -(FX + int'($urandom_range(2 * FX)));
        send_point(t_coord'(a), t_coord'(a - k));
        send_point(t_coord'(b), t_coord'(b - k));
    endtask

    task automatic run_random(input int count);
        int target;
        target = points_sent + count;
        while (points_sent < target) begin
            if ($urandom_range(99) < 4) begin
                send_escape_pair();
            end else begin
                send_point(pick_coord(last_x), pick_coord(last_y));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats: inside points, each edge, zero deltas, the extremes of the
        // coordinate range, the quotient cap and the pass limit.
        send_point('0, '0);
        send_point(t_coord'(FX), t_coord'(FX));
        send_point(t_coord'(-FX), t_coord'(FX / 2));
        send_point(t_coord'(2 * FX), t_coord'(FX / 2));
        send_point(t_coord'(FX / 2), t_coord'(-FX));
        send_point(t_coord'(FX / 2), t_coord'(3 * FX));
        send_point(t_coord'(FX + 1), t_coord'(FX + 1));
        send_point(t_coord'(-1), t_coord'(-1));
        send_point(CW_MAX, CW_MAX);
        send_point(CW_MIN, CW_MIN);
        send_point(CW_MIN, CW_MAX);
        send_point(CW_MAX, CW_MIN);
        send_point(CW_MIN + t_coord'(1), CW_MAX);
        send_point(CW_MIN, CW_MIN);
        send_point(t_coord'(10 * FX), t_coord'(7 * FX));
        send_point(t_coord'(-FX), t_coord'(-4 * FX));
        send_point('0, t_coord'(FX));
        send_point(t_coord'(FX), '0);
        send_point('0, '0);
        send_point(t_coord'(FX - 1), t_coord'(FX + 1));

        run_random(PHASE_ITEMS);

        src_idle_pct = 61;
        dst_stall_pct <= 16;
        run_random(PHASE_ITEMS);

        src_idle_pct = 0;
        dst_stall_pct <= 0;
        run_random(PHASE_ITEMS);

        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d points under three idle profiles, directed edge cases first.",
                 points_sent);
        $display("Results seen: %0d inside, %0d clipped, %0d zero delta, %0d gave up.",
                 status_seen[ST_INSIDE], status_seen[ST_CLIPPED],
                 status_seen[ST_ZERO_DELTA], status_seen[ST_GAVE_UP]);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== clip_point_to_unit_window.f =====
rtl/cpuw_pkg.sv
rtl/cpuw_muldiv.sv
rtl/clip_point_to_unit_window.sv
rtl/cpuw_checker.sv
verif/placed_point_checker.sv
verif/clip_point_to_unit_window_test.sv
